// File: rtl/stcs_pkg.sv
// Shared types, constants and helpers for the stick channel and telemetry scaler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package stcs_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int FULL_SCALE   = 4095;
    localparam int CENTER_RESET = 2048;

    // Stick channels
    localparam int CH_W     = 8;
    localparam int CH_MID   = 100;
    localparam int DEADBAND = 10;
    localparam int PCT_SCALE = 100;

    // Dial angles: base + 45 * x / 100, the divide by 100 done by reciprocal
    localparam int DIAL_LOW   = 135;
    localparam int DIAL_MID   = 180;
    localparam int DIAL_SPAN  = 45;
    localparam int DIAL_SHIFT = 19;
    localparam int DIAL_RECIP = (2**DIAL_SHIFT + PCT_SCALE - 1) / PCT_SCALE;

    // Shared divider: quotient is at most 100, so 7 restoring steps
    localparam int Q_W    = 7;
    localparam int DIV_W  = SAMPLE_W;
    localparam int NUM_W  = 19;
    localparam int DSH_W  = DIV_W + Q_W - 1;
    localparam int STEP_W = $clog2(Q_W);

    // Telemetry conversion
    localparam int ADC_SCALE   = 2890;
    localparam int ADC_SHIFT   = 12;
    localparam int CONV_W      = SAMPLE_W;
    localparam int TEMP_OFFSET = 760;
    localparam int TEMP_GAIN   = 10;
    localparam int TEMP_DIV    = 25;
    localparam int TEMP_BASE   = 25;
    localparam int TN_W        = 16;
    localparam int TDIV_SHIFT  = 17;
    localparam int TDIV_RECIP  = (2**TDIV_SHIFT + TEMP_DIV - 1) / TEMP_DIV;
    localparam int TQ_W        = 10;
    localparam int BAT_W       = 13;
    localparam int TEMP_W      = 11;
    localparam int BAT_MAX     = 5778;
    localparam int TEMP_MAX    = 876;

    // Averaging window
    localparam int AVG_COUNT = 10;
    localparam int CNT_W     = $clog2(AVG_COUNT + 1);
    localparam int BSUM_W    = $clog2(AVG_COUNT * BAT_MAX + 1);
    localparam int TSUM_W    = $clog2(AVG_COUNT * TEMP_MAX + 1) + 1;
    localparam int AVG_SHIFT = 21;
    localparam int AVG_RECIP = (2**AVG_SHIFT + AVG_COUNT - 1) / AVG_COUNT;
    localparam int RECIP_W   = AVG_SHIFT + 1;

    // Configuration port
    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEER_CENTER    = 4'd0,
        REG_THROTTLE_CENTER = 4'd1
    } t_cfg_reg;

    typedef enum logic {
        CH_STEER    = 1'b0,
        CH_THROTTLE = 1'b1
    } t_chan;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SDIV_LD,
        ST_SDIV,
        ST_TDIV_LD,
        ST_TDIV,
        ST_CHAN,
        ST_DIAL,
        ST_ACC,
        ST_AVG,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic  capture;
        logic  div_load;
        t_chan div_sel;
        logic  div_step;
        logic  save_chan;
        t_chan chan_sel;
        logic  tele_a;
        logic  tele_b;
        logic  tele_c;
        logic  dial;
        logic  acc;
        logic  avg;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Dial angle for a channel value; x is the distance from the base of its half.
    function automatic logic [CH_W-1:0] dial_of(input logic [CH_W-1:0] ch,
                                                input logic low_side);
        logic [Q_W-1:0]   x;
        logic [BAT_W-1:0] p;
        logic [24:0]      q;
        x = low_side ? ch[Q_W-1:0] : Q_W'(ch - CH_W'(CH_MID));
        p = BAT_W'(x) * BAT_W'(DIAL_SPAN);
        q = 25'(p) * 25'(DIAL_RECIP);
        return (low_side ? CH_W'(DIAL_LOW) : CH_W'(DIAL_MID)) + CH_W'(q >> DIAL_SHIFT);
    endfunction

endpackage

// File: rtl/stcs_in_if.sv
// Sample channel: four converter samples per transaction.
// Depends on stcs_pkg for field widths.
interface stcs_in_if;
    logic                             valid;
    logic                             ready;
    logic [stcs_pkg::SAMPLE_W-1:0]    steer_sample;
    logic [stcs_pkg::SAMPLE_W-1:0]    throttle_sample;
    logic [stcs_pkg::SAMPLE_W-1:0]    temp_sample;
    logic [stcs_pkg::SAMPLE_W-1:0]    battery_sample;

    modport source (output valid, steer_sample, throttle_sample, temp_sample,
                    battery_sample, input ready);
    modport sink   (input valid, steer_sample, throttle_sample, temp_sample,
                    battery_sample, output ready);
endinterface

// File: rtl/stcs_out_if.sv
// Result channel: stick channels, dial angles and averaged telemetry.
// Depends on stcs_pkg for field widths.
interface stcs_out_if;
    logic                                valid;
    logic                                ready;
    logic [stcs_pkg::CH_W-1:0]           steer_channel;
    logic [stcs_pkg::CH_W-1:0]           throttle_channel;
    logic [stcs_pkg::CH_W-1:0]           steer_dial;
    logic [stcs_pkg::CH_W-1:0]           throttle_dial;
    logic [stcs_pkg::BAT_W-1:0]          battery_mv;
    logic signed [stcs_pkg::TEMP_W-1:0]  temperature_c;
    logic                                averages_updated;

    modport source (output valid, steer_channel, throttle_channel, steer_dial,
                    throttle_dial, battery_mv, temperature_c, averages_updated,
                    input ready);
    modport sink   (input valid, steer_channel, throttle_channel, steer_dial,
                    throttle_dial, battery_mv, temperature_c, averages_updated,
                    output ready);
endinterface

// File: rtl/stcs_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on stcs_pkg for field widths.
interface stcs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [stcs_pkg::CFG_IDX_W-1:0]   index;
    logic [stcs_pkg::SAMPLE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/stcs_top.sv
// Top level of the stick channel and telemetry scaler: sequencer plus datapath.
// Depends on stcs_pkg, stcs_in_if, stcs_out_if, stcs_cfg_if, stcs_ctrl, stcs_dp.
//
//  Channel  | Dir | Interface   | Payload
//  ---------+-----+-------------+------------------------------------------------
//  i_in     | in  | stcs_in_if  | steer/throttle/temp/battery samples, 12 b each
//  o_out    | out | stcs_out_if | channels, dials, battery_mv, temperature_c, flag
//  i_cfg    | in  | stcs_cfg_if | index (0 steer center, 1 throttle center), data
//
// Each transaction passes from acceptance to the result register through the sequencer's
// steps, most of them spent in the shared 7-step restoring divider, run once per stick.
// Samples are taken only while the sequencer is idle; a finished result waits
// in its own register, so the next transaction is accepted while it is unread.
// A result stalled downstream holds the sequencer in its last step.
// Synchronous active-low reset: centers to 2048, sums, count and averages to 0.
// Config writes are always accepted (ready tied high).
module stick_channel_and_telemetry_scaler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stcs_in_if.sink     i_in,
    stcs_out_if.source  o_out,
    stcs_cfg_if.sink    i_cfg
);

    stcs_pkg::t_dp_cmd  cmd;
    stcs_pkg::t_dp_stat stat;
    logic               in_ready;

    // register file never back-pressures
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    stcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    stcs_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_steer_sample     (i_in.steer_sample),
        .i_throttle_sample  (i_in.throttle_sample),
        .i_temp_sample      (i_in.temp_sample),
        .i_battery_sample   (i_in.battery_sample),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_steer_channel    (o_out.steer_channel),
        .o_throttle_channel (o_out.throttle_channel),
        .o_steer_dial       (o_out.steer_dial),
        .o_throttle_dial    (o_out.throttle_dial),
        .o_battery_mv       (o_out.battery_mv),
        .o_temperature_c    (o_out.temperature_c),
        .o_averages_updated (o_out.averages_updated)
    );

endmodule

// File: rtl/stcs_ctrl.sv
// Sequencer for the scaler: walks each transaction through the datapath steps.
// Depends on stcs_pkg (state enum, command and status structs).
module stcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output stcs_pkg::t_dp_cmd  o_cmd,
    input  stcs_pkg::t_dp_stat i_stat
);

    stcs_pkg::t_state                 r_state, n_state;
    logic [stcs_pkg::STEP_W-1:0]      r_step, n_step;

    localparam logic [stcs_pkg::STEP_W-1:0] LAST_STEP = stcs_pkg::STEP_W'(stcs_pkg::Q_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stcs_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            stcs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = stcs_pkg::ST_SDIV_LD;
                end
            end
            stcs_pkg::ST_SDIV_LD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = stcs_pkg::CH_STEER;
                o_cmd.tele_a   = 1'b1;
                n_step         = '0;
                n_state        = stcs_pkg::ST_SDIV;
            end
            stcs_pkg::ST_SDIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = stcs_pkg::ST_TDIV_LD;
                end
            end
            stcs_pkg::ST_TDIV_LD: begin
                o_cmd.save_chan = 1'b1;
                o_cmd.chan_sel  = stcs_pkg::CH_STEER;
                o_cmd.div_load  = 1'b1;
                o_cmd.div_sel   = stcs_pkg::CH_THROTTLE;
                o_cmd.tele_b    = 1'b1;
                n_step          = '0;
                n_state         = stcs_pkg::ST_TDIV;
            end
            stcs_pkg::ST_TDIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = stcs_pkg::ST_CHAN;
                end
            end
            stcs_pkg::ST_CHAN: begin
                o_cmd.save_chan = 1'b1;
                o_cmd.chan_sel  = stcs_pkg::CH_THROTTLE;
                o_cmd.tele_c    = 1'b1;
                n_state         = stcs_pkg::ST_DIAL;
            end
            stcs_pkg::ST_DIAL: begin
                o_cmd.dial = 1'b1;
                n_state    = stcs_pkg::ST_ACC;
            end
            stcs_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = stcs_pkg::ST_AVG;
            end
            stcs_pkg::ST_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = stcs_pkg::ST_FINISH;
            end
            stcs_pkg::ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = stcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/stcs_dp.sv
// Datapath for the scaler: center registers, shared restoring divider,
// channel and dial mapping, telemetry conversion, averaging and output register.
// Depends on stcs_pkg (constants, command/status structs, dial_of).
module stcs_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stcs_pkg::t_dp_cmd                  i_cmd,
    output stcs_pkg::t_dp_stat                 o_stat,
    // sample payload
    input  logic [stcs_pkg::SAMPLE_W-1:0]      i_steer_sample,
    input  logic [stcs_pkg::SAMPLE_W-1:0]      i_throttle_sample,
    input  logic [stcs_pkg::SAMPLE_W-1:0]      i_temp_sample,
    input  logic [stcs_pkg::SAMPLE_W-1:0]      i_battery_sample,
    // register writes
    input  logic                               i_cfg_we,
    input  logic [stcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stcs_pkg::SAMPLE_W-1:0]      i_cfg_data,
    // result register
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [stcs_pkg::CH_W-1:0]          o_steer_channel,
    output logic [stcs_pkg::CH_W-1:0]          o_throttle_channel,
    output logic [stcs_pkg::CH_W-1:0]          o_steer_dial,
    output logic [stcs_pkg::CH_W-1:0]          o_throttle_dial,
    output logic [stcs_pkg::BAT_W-1:0]         o_battery_mv,
    output logic signed [stcs_pkg::TEMP_W-1:0] o_temperature_c,
    output logic                               o_averages_updated
);

    localparam int SW  = stcs_pkg::SAMPLE_W;
    localparam int CW  = stcs_pkg::CH_W;
    localparam int CPW = 2 * SW;
    localparam int BPW = stcs_pkg::BSUM_W + stcs_pkg::RECIP_W;
    localparam int TPW = stcs_pkg::TSUM_W + stcs_pkg::RECIP_W;
    localparam int TMW = stcs_pkg::TN_W - 1;
    localparam int TRW = TMW + 14;

    // centers
    logic [SW-1:0] r_steer_center, r_throttle_center;

    // captured samples
    logic [SW-1:0] r_ss, r_ts, r_ms, r_bs;

    // divider
    logic [stcs_pkg::NUM_W-1:0] r_rem;
    logic [stcs_pkg::DSH_W-1:0] r_dsh;
    logic [stcs_pkg::Q_W-1:0]   r_q;
    logic                       r_low, r_zero;

    // channels and dials
    logic [CW-1:0] r_sch, r_tch, r_sdial, r_tdial;

    // telemetry
    logic [stcs_pkg::CONV_W-1:0]          r_t0;
    logic [stcs_pkg::BAT_W-1:0]           r_bat;
    logic signed [stcs_pkg::TN_W-1:0]     r_tn;
    logic signed [stcs_pkg::TEMP_W-1:0]   r_temp;

    // averaging
    logic [stcs_pkg::BSUM_W-1:0]          r_bsum, r_bfin;
    logic signed [stcs_pkg::TSUM_W-1:0]   r_tsum, r_tfin;
    logic [stcs_pkg::CNT_W-1:0]           r_cnt;
    logic                                 r_upd;
    logic [stcs_pkg::BAT_W-1:0]           r_bavg;
    logic signed [stcs_pkg::TEMP_W-1:0]   r_tavg;

    // result register
    logic                                 r_out_valid;
    logic [CW-1:0]                        r_o_sch, r_o_tch, r_o_sdial, r_o_tdial;
    logic [stcs_pkg::BAT_W-1:0]           r_o_bat;
    logic signed [stcs_pkg::TEMP_W-1:0]   r_o_temp;
    logic                                 r_o_upd;

    // divider load operands
    logic [SW-1:0]              ld_center, ld_sample, ld_diff, ld_divisor;
    logic                       ld_low;
    logic [stcs_pkg::NUM_W-1:0] ld_num;
    logic                       step_fit;
    logic [stcs_pkg::Q_W-1:0]   pct;
    logic [CW-1:0]              pct_w;

    // telemetry helpers
    logic [CPW-1:0]                   t_prod, b_prod;
    logic signed [stcs_pkg::TN_W-1:0] t_delta;
    logic                             tn_neg;
    logic [TMW-1:0]                   tn_mag;
    logic [TRW-1:0]                   tq_prod;
    logic [stcs_pkg::TQ_W-1:0]        tq;

    // averaging helpers
    logic [stcs_pkg::BSUM_W-1:0]        bsum_n;
    logic signed [stcs_pkg::TSUM_W-1:0] tsum_n;
    logic [stcs_pkg::CNT_W-1:0]         cnt_n;
    logic [BPW-1:0]                     bavg_prod;
    logic                               tfin_neg;
    logic [stcs_pkg::TSUM_W-1:0]        tfin_mag;
    logic [TPW-1:0]                     tavg_prod;
    logic [stcs_pkg::TEMP_W-1:0]        tavg_q;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        ld_center  = (i_cmd.div_sel == stcs_pkg::CH_THROTTLE) ? r_throttle_center
                                                              : r_steer_center;
        ld_sample  = (i_cmd.div_sel == stcs_pkg::CH_THROTTLE) ? r_ts : r_ss;
        ld_low     = ld_center > ld_sample;
        ld_diff    = ld_low ? (ld_center - ld_sample) : (ld_sample - ld_center);
        ld_divisor = ld_low ? ld_center : (SW'(stcs_pkg::FULL_SCALE) - ld_center);
        ld_num     = stcs_pkg::NUM_W'(ld_diff) * stcs_pkg::NUM_W'(stcs_pkg::PCT_SCALE);
        step_fit   = stcs_pkg::NUM_W'(r_dsh) <= r_rem;

        // dead band and zero divisor both give no deflection
        pct   = (r_zero || (r_q <= stcs_pkg::Q_W'(stcs_pkg::DEADBAND))) ? '0 : r_q;
        pct_w = CW'(pct);

        t_prod  = CPW'(r_ms) * CPW'(stcs_pkg::ADC_SCALE);
        b_prod  = CPW'(r_bs) * CPW'(stcs_pkg::ADC_SCALE);
        t_delta = $signed({{(stcs_pkg::TN_W - stcs_pkg::CONV_W){1'b0}}, r_t0})
                  - stcs_pkg::TN_W'(stcs_pkg::TEMP_OFFSET);
        tn_neg  = r_tn[stcs_pkg::TN_W-1];
        tn_mag  = tn_neg ? TMW'(-r_tn) : TMW'(r_tn);
        tq_prod = TRW'(tn_mag) * TRW'(stcs_pkg::TDIV_RECIP);
        tq      = stcs_pkg::TQ_W'(tq_prod >> stcs_pkg::TDIV_SHIFT);

        bsum_n = r_bsum + stcs_pkg::BSUM_W'(r_bat);
        tsum_n = r_tsum + stcs_pkg::TSUM_W'(r_temp);
        cnt_n  = r_cnt + 1'b1;

        bavg_prod = BPW'(r_bfin) * BPW'(stcs_pkg::AVG_RECIP);
        tfin_neg  = r_tfin[stcs_pkg::TSUM_W-1];
        tfin_mag  = tfin_neg ? stcs_pkg::TSUM_W'(-r_tfin) : stcs_pkg::TSUM_W'(r_tfin);
        tavg_prod = TPW'(tfin_mag) * TPW'(stcs_pkg::AVG_RECIP);
        tavg_q    = stcs_pkg::TEMP_W'(tavg_prod >> stcs_pkg::AVG_SHIFT);
    end

    // control state: centers, window, averages, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_center    <= SW'(stcs_pkg::CENTER_RESET);
            r_throttle_center <= SW'(stcs_pkg::CENTER_RESET);
            r_bsum            <= '0;
            r_tsum            <= '0;
            r_cnt             <= '0;
            r_upd             <= 1'b0;
            r_bavg            <= '0;
            r_tavg            <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (stcs_pkg::t_cfg_reg'(i_cfg_index))
                    stcs_pkg::REG_STEER_CENTER:    r_steer_center    <= i_cfg_data;
                    stcs_pkg::REG_THROTTLE_CENTER: r_throttle_center <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                if (cnt_n == stcs_pkg::CNT_W'(stcs_pkg::AVG_COUNT)) begin
                    r_bsum <= '0;
                    r_tsum <= '0;
                    r_cnt  <= '0;
                    r_upd  <= 1'b1;
                end else begin
                    r_bsum <= bsum_n;
                    r_tsum <= tsum_n;
                    r_cnt  <= cnt_n;
                    r_upd  <= 1'b0;
                end
            end
            if (i_cmd.avg && r_upd) begin
                r_bavg <= stcs_pkg::BAT_W'(bavg_prod >> stcs_pkg::AVG_SHIFT);
                r_tavg <= tfin_neg ? -$signed(tavg_q) : $signed(tavg_q);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ss <= i_steer_sample;
            r_ts <= i_throttle_sample;
            r_ms <= i_temp_sample;
            r_bs <= i_battery_sample;
        end
        if (i_cmd.div_load) begin
            r_rem  <= ld_num;
            r_dsh  <= {ld_divisor, {(stcs_pkg::Q_W - 1){1'b0}}};
            r_q    <= '0;
            r_low  <= ld_low;
            r_zero <= (ld_divisor == '0);
        end else if (i_cmd.div_step) begin
            if (step_fit) begin
                r_rem <= r_rem - stcs_pkg::NUM_W'(r_dsh);
            end
            r_q   <= {r_q[stcs_pkg::Q_W-2:0], step_fit};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.save_chan) begin
            if (i_cmd.chan_sel == stcs_pkg::CH_STEER) begin
                r_sch <= r_low ? (CW'(stcs_pkg::CH_MID) - pct_w)
                               : (CW'(stcs_pkg::CH_MID) + pct_w);
            end else begin
                r_tch <= r_low ? (CW'(stcs_pkg::CH_MID) + pct_w)
                               : (CW'(stcs_pkg::CH_MID) - pct_w);
            end
        end
        if (i_cmd.tele_a) begin
            r_t0  <= stcs_pkg::CONV_W'(t_prod >> stcs_pkg::ADC_SHIFT);
            r_bat <= {stcs_pkg::CONV_W'(b_prod >> stcs_pkg::ADC_SHIFT), 1'b0};
        end
        if (i_cmd.tele_b) begin
            r_tn <= stcs_pkg::TN_W'(t_delta * stcs_pkg::TN_W'(stcs_pkg::TEMP_GAIN));
        end
        if (i_cmd.tele_c) begin
            // truncation toward zero, then the 25 degree offset
            r_temp <= tn_neg
                ? stcs_pkg::TEMP_W'(stcs_pkg::TEMP_BASE) - stcs_pkg::TEMP_W'(tq)
                : stcs_pkg::TEMP_W'(stcs_pkg::TEMP_BASE) + stcs_pkg::TEMP_W'(tq);
        end
        if (i_cmd.dial) begin
            r_sdial <= stcs_pkg::dial_of(r_sch, r_sch <= CW'(stcs_pkg::CH_MID));
            r_tdial <= stcs_pkg::dial_of(r_tch, r_tch <  CW'(stcs_pkg::CH_MID));
        end
        if (i_cmd.acc && (cnt_n == stcs_pkg::CNT_W'(stcs_pkg::AVG_COUNT))) begin
            r_bfin <= bsum_n;
            r_tfin <= tsum_n;
        end
        if (i_cmd.out_load) begin
            r_o_sch   <= r_sch;
            r_o_tch   <= r_tch;
            r_o_sdial <= r_sdial;
            r_o_tdial <= r_tdial;
            r_o_bat   <= r_bavg;
            r_o_temp  <= r_tavg;
            r_o_upd   <= r_upd;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_steer_channel    = r_o_sch;
    assign o_throttle_channel = r_o_tch;
    assign o_steer_dial       = r_o_sdial;
    assign o_throttle_dial    = r_o_tdial;
    assign o_battery_mv       = r_o_bat;
    assign o_temperature_c    = r_o_temp;
    assign o_averages_updated = r_o_upd;

endmodule

// File: bench/stick_channel_and_telemetry_scaler_top_tb.sv
// Self-checking bench for stick_channel_and_telemetry_scaler_top: stick channels, dials,
// averaged telemetry, center registers and output backpressure, against an inline predictor.
// Depends on stcs_pkg, stcs_in_if, stcs_out_if, stcs_cfg_if and the RTL of the block.
`timescale 1ns / 100ps

module stick_channel_and_telemetry_scaler_top_tb;

    // Cycles without any transaction on any channel before the run is declared hung.
    // Worst legal gap is the long result hold plus one item's latency and pacing.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_REPORTS    = 100;

    localparam int SW = stcs_pkg::SAMPLE_W;
    localparam int FS = stcs_pkg::FULL_SCALE;

    // One expected result transaction, at the widths of the result channel.
    typedef struct {
        logic [stcs_pkg::CH_W-1:0]          steer_channel;
        logic [stcs_pkg::CH_W-1:0]          throttle_channel;
        logic [stcs_pkg::CH_W-1:0]          steer_dial;
        logic [stcs_pkg::CH_W-1:0]          throttle_dial;
        logic [stcs_pkg::BAT_W-1:0]         battery_mv;
        logic signed [stcs_pkg::TEMP_W-1:0] temperature_c;
        logic                               averages_updated;
    } t_scaled_frame;

    logic i_clk;
    logic i_rst_n;

    stcs_in_if  samples_if ();
    stcs_out_if results_if ();
    stcs_cfg_if cfg_if ();

    stick_channel_and_telemetry_scaler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (samples_if),
        .o_out   (results_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: a mirror of the block's registers and averaging window
    logic [SW-1:0] steer_ctr;
    logic [SW-1:0] throttle_ctr;
    int            bat_sum;
    int            temp_sum;
    int            window_fill;
    int            bat_avg;
    int            temp_avg;

    t_scaled_frame pending_frames[$];

    // Pacing controls shared by the sender, the result process and the tests
    bit tx_paced = 1'b1;
    bit rx_paced = 1'b1;
    int rx_hold_cycles = 0;

    // Run statistics
    int fail_count      = 0;
    int frames_checked  = 0;
    int windows_closed  = 0;
    int center_settings = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Deflection percentage after the dead band; below is set on the low side.
    // A center of full scale leaves no high side, which reads as zero.
    function automatic int deflection_pct(input int sample, input int center,
                                          output bit below);
        int pct;
        below = center > sample;
        if (below)
            pct = (stcs_pkg::PCT_SCALE * (center - sample)) / center;
        else if (center == FS)
            pct = 0;
        else
            pct = (stcs_pkg::PCT_SCALE * (sample - center)) / (FS - center);
        return (pct <= stcs_pkg::DEADBAND) ? 0 : pct;
    endfunction

    function automatic int dial_angle(input int ch, input bit low_half);
        if (low_half)
            return stcs_pkg::DIAL_LOW + (stcs_pkg::DIAL_SPAN * ch) / stcs_pkg::PCT_SCALE;
        return stcs_pkg::DIAL_MID
               + (stcs_pkg::DIAL_SPAN * (ch - stcs_pkg::CH_MID)) / stcs_pkg::PCT_SCALE;
    endfunction

    function automatic void reset_model();
        steer_ctr    = SW'(stcs_pkg::CENTER_RESET);
        throttle_ctr = SW'(stcs_pkg::CENTER_RESET);
        bat_sum      = 0;
        temp_sum     = 0;
        window_fill  = 0;
        bat_avg      = 0;
        temp_avg     = 0;
    endfunction

    // Scales one sample set and advances the averaging window.
    function automatic t_scaled_frame scale_samples(input logic [SW-1:0] ss,
                                                    input logic [SW-1:0] ts,
                                                    input logic [SW-1:0] ms,
                                                    input logic [SW-1:0] bs);
        t_scaled_frame f;
        bit            below;
        int            pct;
        int            sch;
        int            tch;
        int            temp_c;
        int            bat;
        int            raw;

        pct = deflection_pct(int'(ss), int'(steer_ctr), below);
        sch = below ? stcs_pkg::CH_MID - pct : stcs_pkg::CH_MID + pct;
        // Throttle runs the other way: forward is below the rest position
        pct = deflection_pct(int'(ts), int'(throttle_ctr), below);
        tch = below ? stcs_pkg::CH_MID + pct : stcs_pkg::CH_MID - pct;

        // Signed temperature; SV integer division truncates toward zero
        raw    = (int'(ms) * stcs_pkg::ADC_SCALE) >> stcs_pkg::ADC_SHIFT;
        temp_c = (stcs_pkg::TEMP_GAIN * (raw - stcs_pkg::TEMP_OFFSET)) / stcs_pkg::TEMP_DIV
                 + stcs_pkg::TEMP_BASE;
        bat    = ((int'(bs) * stcs_pkg::ADC_SCALE) >> stcs_pkg::ADC_SHIFT) * 2;

        temp_sum    += temp_c;
        bat_sum     += bat;
        window_fill += 1;
        f.averages_updated = 1'b0;
        if (window_fill >= stcs_pkg::AVG_COUNT) begin
            bat_avg     = bat_sum / stcs_pkg::AVG_COUNT;
            temp_avg    = temp_sum / stcs_pkg::AVG_COUNT;
            window_fill = 0;
            bat_sum     = 0;
            temp_sum    = 0;
            f.averages_updated = 1'b1;
        end

        f.steer_channel    = stcs_pkg::CH_W'(sch);
        f.throttle_channel = stcs_pkg::CH_W'(tch);
        // Steering counts 100 as the low half, throttle does not
        f.steer_dial       = stcs_pkg::CH_W'(dial_angle(sch, sch <= stcs_pkg::CH_MID));
        f.throttle_dial    = stcs_pkg::CH_W'(dial_angle(tch, tch < stcs_pkg::CH_MID));
        f.battery_mv       = stcs_pkg::BAT_W'(bat_avg);
        f.temperature_c    = stcs_pkg::TEMP_W'(temp_avg);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Sample channel driver
    // ------------------------------------------------------------------

    // Offers one sample set and returns at the edge where it is accepted.
    // valid stays high afterwards so back-to-back transactions need no extra edge.
    task automatic send_samples(input logic [SW-1:0] ss, input logic [SW-1:0] ts,
                                input logic [SW-1:0] ms, input logic [SW-1:0] bs);
        int gap;
        gap = tx_paced ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        samples_if.valid           <= 1'b1;
        samples_if.steer_sample    <= ss;
        samples_if.throttle_sample <= ts;
        samples_if.temp_sample     <= ms;
        samples_if.battery_sample  <= bs;
        do @(posedge i_clk); while (!(samples_if.valid === 1'b1 && samples_if.ready === 1'b1));
        pending_frames.push_back(scale_samples(ss, ts, ms, bs));
    endtask

    // Stops offering and waits until every expected result has been read.
    task automatic drain_results();
        samples_if.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input stcs_pkg::t_cfg_reg idx, input logic [SW-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1));
        if (idx == stcs_pkg::REG_STEER_CENTER)
            steer_ctr = value;
        else if (idx == stcs_pkg::REG_THROTTLE_CENTER)
            throttle_ctr = value;
    endtask

    // Centers change only with the block idle; the window carries across.
    task automatic set_centers(input logic [SW-1:0] steer,
                               input logic [SW-1:0] throttle);
        drain_results();
        cfg_write(stcs_pkg::REG_STEER_CENTER, steer);
        cfg_write(stcs_pkg::REG_THROTTLE_CENTER, throttle);
        cfg_if.valid <= 1'b0;
        center_settings++;
    endtask

    // ------------------------------------------------------------------
    // Random sample shaping
    // ------------------------------------------------------------------

    // Mostly full range, with weight on the rest position and the dead band edges.
    function automatic logic [SW-1:0] stick_sample(input logic [SW-1:0] ctr);
        int v;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel inside {[0:4]})
            v = $urandom_range(0, FS);
        else if (sel inside {[5:7]})
            v = int'(ctr) + int'($urandom_range(0, 500)) - 250;
        else if (sel == 8)
            v = $urandom_range(0, 1) ? FS : 0;
        else
            v = int'(ctr) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(200, 240));
        if (v < 0) v = 0;
        if (v > FS) v = FS;
        return SW'(v);
    endfunction

    function automatic logic [SW-1:0] telemetry_sample();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? SW'(FS) : SW'(0);
        return SW'($urandom_range(0, FS));
    endfunction

    function automatic logic [SW-1:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return SW'($urandom_range(0, 1));
            1:       return SW'(FS - int'($urandom_range(0, 1)));
            default: return SW'($urandom_range(0, FS));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input integer want, input integer got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    // Reads result transactions with random stalls; a requested hold is counted here.
    initial begin : result_reader
        int            stall;
        t_scaled_frame want;
        results_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = 0;
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (rx_paced) begin
                stall = $urandom_range(0, 3);
            end
            if (stall > 0) begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(results_if.valid === 1'b1 && results_if.ready === 1'b1));

            if (pending_frames.size() == 0) begin
                fail_count++;
                $display("%0t: result transaction with nothing expected", $time);
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (want.averages_updated) windows_closed++;
                check_field("steer_channel", want.steer_channel, results_if.steer_channel);
                check_field("throttle_channel", want.throttle_channel,
                            results_if.throttle_channel);
                check_field("steer_dial", want.steer_dial, results_if.steer_dial);
                check_field("throttle_dial", want.throttle_dial, results_if.throttle_dial);
                check_field("battery_mv", want.battery_mv, results_if.battery_mv);
                check_field("temperature_c", want.temperature_c,
                            $signed(results_if.temperature_c));
                check_field("averages_updated", want.averages_updated,
                            results_if.averages_updated);
            end
        end
    end

    // Hang detector: ends the run after too long without any transaction.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((samples_if.valid === 1'b1 && samples_if.ready === 1'b1) ||
                (results_if.valid === 1'b1 && results_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset centers (2048): rest, full deflection, both sides of the dead band,
    // telemetry extremes; twelve items so one averaging window closes.
    task automatic test_default_centers();
        send_samples(12'd2048, 12'd2048, 12'd0,    12'd0);
        send_samples(12'd0,    12'd4095, 12'd4095, 12'd4095);
        send_samples(12'd4095, 12'd0,    12'd0,    12'd4095);
        send_samples(12'd2047, 12'd2049, 12'd4095, 12'd0);
        send_samples(12'd1833, 12'd2263, 12'd1077, 12'd2048);  // inside dead band
        send_samples(12'd1822, 12'd2274, 12'd1078, 12'd1);     // just outside it
        send_samples(12'd2263, 12'd1833, 12'd2000, 12'd2222);
        send_samples(12'd2274, 12'd1822, 12'd1,    12'd4094);
        send_samples(12'd1024, 12'd3072, 12'd3333, 12'd1500);
        send_samples(12'd3072, 12'd1024, 12'd0,    12'd4095);  // closes window
        send_samples(12'd2048, 12'd2048, 12'd4095, 12'd4095);
        send_samples(12'd100,  12'd4000, 12'd0,    12'd0);
    endtask

    // Centers at the rails: no low side at 0, zero high-side span at full scale.
    task automatic test_center_extremes();
        set_centers(12'd0, 12'd4095);
        send_samples(12'd0,    12'd4095, 12'd2048, 12'd2048);
        send_samples(12'd4095, 12'd0,    12'd4095, 12'd4095);
        send_samples(12'd409,  12'd3686, 12'd0,    12'd0);
        send_samples(12'd410,  12'd3685, 12'd1234, 12'd3210);
        set_centers(12'd4095, 12'd0);
        send_samples(12'd4095, 12'd0,    12'd4095, 12'd0);
        send_samples(12'd0,    12'd4095, 12'd0,    12'd4095);
        send_samples(12'd3686, 12'd409,  12'd2500, 12'd777);
        send_samples(12'd3685, 12'd410,  12'd3000, 12'd3000);
    endtask

    // Result side holds off for a long stretch while samples keep coming,
    // so the result register fills and the sequencer must stall its input.
    task automatic test_output_backpressure();
        set_centers(12'd2048, 12'd2048);
        rx_hold_cycles = HOLD_CYCLES;
        tx_paced = 1'b0;
        repeat (10)
            send_samples(stick_sample(steer_ctr), stick_sample(throttle_ctr),
                         telemetry_sample(), telemetry_sample());
        tx_paced = 1'b1;
    endtask

    // Random sample sets over several center settings, pacing redrawn in blocks
    // so that some stretches run with no idling on either side.
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++) begin
            set_centers(pick_center(), pick_center());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    tx_paced = $urandom_range(0, 3) != 0;
                    rx_paced = $urandom_range(0, 3) != 0;
                end
                send_samples(stick_sample(steer_ctr), stick_sample(throttle_ctr),
                             telemetry_sample(), telemetry_sample());
            end
        end
        tx_paced = 1'b1;
        rx_paced = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        samples_if.valid           <= 1'b0;
        samples_if.steer_sample    <= '0;
        samples_if.throttle_sample <= '0;
        samples_if.temp_sample     <= '0;
        samples_if.battery_sample  <= '0;
        cfg_if.valid               <= 1'b0;
        cfg_if.index               <= stcs_pkg::REG_STEER_CENTER;
        cfg_if.data                <= '0;
        i_rst_n                    <= 1'b0;
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_centers();
        test_center_extremes();
        test_output_backpressure();
        test_random_traffic();

        // Drain, then let any stray result show itself
        drain_results();
        repeat (30) @(posedge i_clk);

        $display("Checked %0d result transactions over %0d center settings.",
                 frames_checked, center_settings + 1);
        $display("Averaging windows closed: %0d; long result hold of %0d cycles applied.",
                 windows_closed, HOLD_CYCLES);
        if (fail_count == 0 && pending_frames.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
